@@ rtl/cartridge_bank_controller_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the cartridge bank controller
// Clocked, reset-gated property wrappers used by the controller RTL.
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_BANK_CONTROLLER_ASSERT_SVH
`define CARTRIDGE_BANK_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define CBC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/cbc_pkg.sv @@
// ----------------------------------------------------------------------------
// Cartridge bank controller package
// Shared constants, address map, result and RAM request types.
// ----------------------------------------------------------------------------
package cbc_pkg;

  // default geometry
  localparam int unsigned RAM_BANKS_DEF     = 4;
  localparam int unsigned MAX_ROM_BANKS_DEF = 128;

  // geometry limits set by the bank register widths
  localparam int unsigned BANK_BYTES   = 8192;
  localparam int unsigned ROM_TAB_SIZE = 128;
  localparam int unsigned RAM_TAB_SIZE = 4;

  // configuration register indexes
  localparam logic [1:0] CFG_ROM_BANK_COUNT = 2'd0;
  localparam logic [1:0] CFG_RAM_BANK_COUNT = 2'd1;
  localparam logic [1:0] CFG_BOOT_ROM_SKIP  = 2'd2;

  // data source codes
  localparam logic [1:0] SRC_DATA = 2'd0;
  localparam logic [1:0] SRC_BOOT = 2'd1;
  localparam logic [1:0] SRC_ROM  = 2'd2;

  // address map
  localparam logic [15:0] ADDR_RAM_EN_END  = 16'h1FFF;
  localparam logic [15:0] ADDR_ROM_LO_END  = 16'h3FFF;
  localparam logic [15:0] ADDR_BANK_HI_END = 16'h5FFF;
  localparam logic [15:0] ADDR_ROM_END     = 16'h7FFF;
  localparam logic [15:0] ADDR_RAM_BEGIN   = 16'hA000;
  localparam logic [15:0] ADDR_RAM_END     = 16'hBFFF;
  localparam logic [15:0] ADDR_BOOT_END    = 16'h00FF;
  localparam logic [15:0] ADDR_BOOT_OFF    = 16'hFF50;
  localparam logic [3:0]  RAM_EN_KEY       = 4'hA;

  typedef struct packed {
    logic        cpu_ack;
    logic        dma_ack;
    logic [7:0]  read_data;
    logic [1:0]  data_source;
    logic [20:0] memory_address;
    logic        ram_written;
  } result_t;

  typedef struct packed {
    logic        we;
    logic        re;
    logic [1:0]  bank;
    logic [12:0] offset;
    logic [7:0]  wdata;
  } ram_req_t;

  function automatic logic in_space(input logic [15:0] a);
    in_space = (a <= ADDR_ROM_END) || ((a >= ADDR_RAM_BEGIN) && (a <= ADDR_RAM_END));
  endfunction

  function automatic logic in_ram(input logic [15:0] a);
    in_ram = (a >= ADDR_RAM_BEGIN) && (a <= ADDR_RAM_END);
  endfunction

endpackage

@@ rtl/cbc_if.sv @@
// ----------------------------------------------------------------------------
// Cartridge bank controller channels
// Valid/ready interfaces for access beats in and result beats out.
// ----------------------------------------------------------------------------
interface cbc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] cpu_addr;
  logic [7:0]  cpu_data;
  logic        cpu_read;
  logic        cpu_write;
  logic [15:0] dma_addr;
  logic [7:0]  dma_data;
  logic        dma_read;
  logic        dma_write;

  modport source (
    output valid, cpu_addr, cpu_data, cpu_read, cpu_write,
           dma_addr, dma_data, dma_read, dma_write,
    input  ready
  );
  modport sink (
    input  valid, cpu_addr, cpu_data, cpu_read, cpu_write,
           dma_addr, dma_data, dma_read, dma_write,
    output ready
  );
endinterface

interface cbc_out_if;
  logic        valid;
  logic        ready;
  logic        cpu_ack;
  logic        dma_ack;
  logic [7:0]  read_data;
  logic [1:0]  data_source;
  logic [20:0] memory_address;
  logic        ram_written;

  modport source (
    output valid, cpu_ack, dma_ack, read_data, data_source, memory_address, ram_written,
    input  ready
  );
  modport sink (
    input  valid, cpu_ack, dma_ack, read_data, data_source, memory_address, ram_written,
    output ready
  );
endinterface

@@ rtl/cbc_ram.sv @@
// ----------------------------------------------------------------------------
// Cartridge RAM
// Banked byte RAM, one read and one write port, registered read data,
// swept to zero after reset.
// ----------------------------------------------------------------------------
module cbc_ram #(
  parameter int unsigned RAM_BANKS = cbc_pkg::RAM_BANKS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cbc_pkg::ram_req_t req,
  output logic [7:0]        rdata,
  output logic              busy
);
  import cbc_pkg::*;

  localparam int unsigned RAM_DEPTH = RAM_BANKS * BANK_BYTES;
  localparam int unsigned RAM_AW    = $clog2(RAM_DEPTH);

  logic [7:0]        mem [RAM_DEPTH];
  logic [7:0]        rdata_r;
  logic              busy_r;
  logic [RAM_AW-1:0] clr_addr_r;
  logic [1:0]        bank_mod [RAM_TAB_SIZE];
  logic [14:0]       idx_full;
  logic [RAM_AW-1:0] idx;

  // bank wrap table
  for (genvar g = 0; g < RAM_TAB_SIZE; g++) begin : g_bank_mod
    assign bank_mod[g] = 2'(g % RAM_BANKS);
  end

  assign idx_full = {bank_mod[req.bank], req.offset};
  assign idx      = idx_full[RAM_AW-1:0];

  // clearing sweep after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      clr_addr_r <= '0;
    end else if (busy_r) begin
      clr_addr_r <= clr_addr_r + RAM_AW'(1);
      if (clr_addr_r == RAM_AW'(RAM_DEPTH - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_addr_r] <= 8'd0;
    end else if (req.we) begin
      mem[idx] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[idx];
    end
  end

  assign rdata = rdata_r;
  assign busy  = busy_r;

endmodule

@@ rtl/cartridge_bank_controller.sv @@
// ----------------------------------------------------------------------------
// Cartridge bank controller
// Banked ROM/RAM mapper serving a CPU port and a DMA port, one access
// pair per beat.
// ----------------------------------------------------------------------------
// Takes one access beat per clock while in_ch.ready is high and returns one
// result beat per access: on acceptance the access is decoded, the bank
// registers are updated and the cart RAM read or write is issued; the
// output register then picks up the registered RAM byte. The cart RAM
// single read port and single write port set this one-beat-per-cycle rate.
// After reset the RAM is swept to zero, RAM_BANKS * 8192 bytes (32768
// by default); in_ch.ready stays low during the sweep while configuration
// writes are still taken. Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module cartridge_bank_controller #(
  parameter int unsigned RAM_BANKS     = cbc_pkg::RAM_BANKS_DEF,
  parameter int unsigned MAX_ROM_BANKS = cbc_pkg::MAX_ROM_BANKS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  cbc_in_if.sink     in_ch,
  cbc_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import cbc_pkg::*;

  `include "cartridge_bank_controller_assert.svh"

  // configuration and bank state
  logic [7:0] rom_bank_count_r;
  logic [4:0] ram_bank_count_r;
  logic       ram_enabled_r;
  logic [4:0] bank_low_r;
  logic [1:0] bank_high_r;
  logic       banking_mode_r;
  logic       boot_rom_off_r;
  logic       ram_dirty_r;

  // pipeline
  logic    s1_v_r;
  logic    s1_mem_r;
  result_t s1_res_r;
  logic    out_v_r;
  result_t out_res_r;
  result_t out_res_nxt;
  logic    s1_adv;

  // decode
  logic        accept;
  logic        dma_hit;
  logic        cpu_hit;
  logic [15:0] a;
  logic [7:0]  d;
  logic        rd;
  logic        wr;
  logic [7:0]  rom_mask;
  logic [6:0]  lo_bank;
  logic [6:0]  hi_raw;
  logic [6:0]  hi_bank;
  logic [6:0]  rom_bank;
  logic [6:0]  rom_mod [ROM_TAB_SIZE];
  logic        ram_ok;
  logic        ram_wr;
  logic        ram_rd;
  result_t     res;
  ram_req_t    ram_req;
  logic [7:0]  ram_rdata;
  logic        ram_busy;

  // ROM bank wrap table
  for (genvar g = 0; g < ROM_TAB_SIZE; g++) begin : g_rom_mod
    assign rom_mod[g] = 7'(g % MAX_ROM_BANKS);
  end

  // access selection: a hitting DMA read wins
  assign dma_hit = in_ch.dma_read && in_space(in_ch.dma_addr);
  assign cpu_hit = (in_ch.cpu_read || in_ch.cpu_write) && in_space(in_ch.cpu_addr);
  assign a  = dma_hit ? in_ch.dma_addr  : in_ch.cpu_addr;
  assign d  = dma_hit ? in_ch.dma_data  : in_ch.cpu_data;
  assign rd = dma_hit ? in_ch.dma_read  : in_ch.cpu_read;
  assign wr = dma_hit ? in_ch.dma_write : in_ch.cpu_write;

  // ROM bank translation
  assign rom_mask = rom_bank_count_r - 8'd1;
  assign lo_bank  = (!banking_mode_r || rom_bank_count_r == 8'd0) ? 7'd0
                  : ({bank_high_r, 5'd0} & rom_mask[6:0]);
  assign hi_raw   = {bank_high_r, (bank_low_r == 5'd0) ? 5'd1 : bank_low_r};
  assign hi_bank  = (rom_bank_count_r != 8'd0) ? (hi_raw & rom_mask[6:0]) : hi_raw;
  assign rom_bank = rom_mod[(a <= ADDR_ROM_LO_END) ? lo_bank : hi_bank];

  // cart RAM access
  assign ram_ok = ram_enabled_r && (ram_bank_count_r != 5'd0) && in_ram(a);
  assign ram_wr = wr && ram_ok;
  assign ram_rd = !wr && rd && ram_ok;

  assign accept      = in_ch.valid && in_ch.ready;
  assign ram_req.we     = accept && ram_wr;
  assign ram_req.re     = accept && ram_rd;
  assign ram_req.bank   = (banking_mode_r ? bank_high_r : 2'd0)
                        & ram_bank_count_r[1:0] - 2'd1;
  assign ram_req.offset = a[12:0];
  assign ram_req.wdata  = d;

  // result of the access
  always_comb begin
    res.cpu_ack        = !dma_hit && cpu_hit;
    res.dma_ack        = dma_hit;
    res.read_data      = d;
    res.data_source    = SRC_DATA;
    res.memory_address = '0;
    res.ram_written    = ram_dirty_r || ram_wr;
    if (!wr && rd) begin
      if (a <= ADDR_BOOT_END && !boot_rom_off_r) begin
        res.data_source    = SRC_BOOT;
        res.memory_address = {13'd0, a[7:0]};
      end else if (a <= ADDR_ROM_END) begin
        res.data_source    = SRC_ROM;
        res.memory_address = {rom_bank, a[13:0]};
      end
    end
  end

  // bank registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_bank_count_r <= '0;
      ram_bank_count_r <= '0;
      ram_enabled_r    <= 1'b0;
      bank_low_r       <= '0;
      bank_high_r      <= '0;
      banking_mode_r   <= 1'b0;
      boot_rom_off_r   <= 1'b0;
      ram_dirty_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ROM_BANK_COUNT: rom_bank_count_r <= cfg_data;
          CFG_RAM_BANK_COUNT: ram_bank_count_r <= cfg_data[4:0];
          CFG_BOOT_ROM_SKIP: begin
            if (cfg_data[0]) boot_rom_off_r <= 1'b1;
          end
          default: ;
        endcase
      end
      if (accept && wr) begin
        if (a <= ADDR_RAM_EN_END) begin
          ram_enabled_r <= (d[3:0] == RAM_EN_KEY);
        end else if (a <= ADDR_ROM_LO_END) begin
          bank_low_r <= d[4:0];
        end else if (a <= ADDR_BANK_HI_END) begin
          bank_high_r <= d[1:0];
        end else if (a <= ADDR_ROM_END) begin
          banking_mode_r <= d[0];
        end else if (a == ADDR_BOOT_OFF && d != 8'd0) begin
          boot_rom_off_r <= 1'b1;
        end
        if (ram_wr) ram_dirty_r <= 1'b1;
      end
    end
  end

  // pipeline control
  assign s1_adv      = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !ram_busy && (!s1_v_r || !out_v_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // output stage next value: RAM reads take the registered byte
  always_comb begin
    out_res_nxt = s1_res_r;
    if (s1_mem_r) out_res_nxt.read_data = ram_rdata;
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res_r <= res;
      s1_mem_r <= ram_rd;
    end
    if (s1_adv) begin
      out_res_r <= out_res_nxt;
    end
  end

  cbc_ram #(
    .RAM_BANKS(RAM_BANKS)
  ) u_ram (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (ram_req),
    .rdata(ram_rdata),
    .busy (ram_busy)
  );

  // output channel
  assign out_ch.valid          = out_v_r;
  assign out_ch.cpu_ack        = out_res_r.cpu_ack;
  assign out_ch.dma_ack        = out_res_r.dma_ack;
  assign out_ch.read_data      = out_res_r.read_data;
  assign out_ch.data_source    = out_res_r.data_source;
  assign out_ch.memory_address = out_res_r.memory_address;
  assign out_ch.ram_written    = out_res_r.ram_written;

  // checks
  `CBC_ASSERT_SAME(a_no_accept_in_sweep, ram_busy, !in_ch.ready, "beat taken during RAM sweep")
  `CBC_ASSERT_NEXT(a_dirty_sticky, ram_dirty_r, ram_dirty_r, "RAM dirty flag cleared")
  `CBC_ASSERT_SAME(a_data_no_addr, out_v_r && out_res_r.data_source == SRC_DATA,
                   out_res_r.memory_address == '0, "address given with data source")
  `CBC_ASSERT_NEXT(a_s1_hold, s1_v_r && !s1_adv, s1_v_r && $stable(s1_res_r),
                   "stalled stage lost its beat")
  `CBC_ASSERT_SAME(a_ram_one_op, accept, !(ram_req.we && ram_req.re),
                   "RAM read and write from one beat")

endmodule

@@ verif/cartridge_bank_controller_tb.sv @@
// ----------------------------------------------------------------------------
// Cartridge bank controller testbench
// Sends CPU/DMA access beats over the input channel while random stalls hit
// both channels, and walks through several bank count and boot settings.
// Each result beat is checked field by field against an in-bench model of
// the bank registers, the boot ROM latch and the cart RAM contents.
// ----------------------------------------------------------------------------
module cartridge_bank_controller_tb;
  import cbc_pkg::*;

  // cycles with no beat on either channel before the run is called hung;
  // covers the RAM clearing sweep after reset with a wide margin
  localparam int unsigned STALL_LIMIT = 120000;
  // cycles allowed after the last result before the verdict
  localparam int unsigned TAIL_CYCLES = 4;

  typedef struct packed {
    logic [15:0] cpu_addr;
    logic [7:0]  cpu_data;
    logic        cpu_read;
    logic        cpu_write;
    logic [15:0] dma_addr;
    logic [7:0]  dma_data;
    logic        dma_read;
    logic        dma_write;
  } access_t;

  // --------------------------------------------------------------------------
  // Bank map model plus the queue of results it has promised
  // --------------------------------------------------------------------------
  class cart_map_tracker;
    logic [7:0]  rom_count;
    logic [4:0]  ram_count;
    logic        boot_skip;
    logic        ram_on;
    logic [4:0]  bank_lo;
    logic [1:0]  bank_hi;
    logic        mode_sel;
    logic        boot_off;
    logic        dirty;
    logic [7:0]  cart_mem [0:RAM_BANKS_DEF*BANK_BYTES-1];
    result_t     due_results[$];
    int unsigned mismatches;

    function new();
      rom_count   = '0;
      ram_count   = '0;
      boot_skip   = 1'b0;
      ram_on      = 1'b0;
      bank_lo     = '0;
      bank_hi     = '0;
      mode_sel    = 1'b0;
      boot_off    = 1'b0;
      dirty       = 1'b0;
      mismatches  = 0;
      foreach (cart_mem[i]) cart_mem[i] = 8'h00;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        CFG_ROM_BANK_COUNT: rom_count = val;
        CFG_RAM_BANK_COUNT: ram_count = val[4:0];
        CFG_BOOT_ROM_SKIP: begin
          // skip only ever turns the boot ROM off
          boot_skip = val[0];
          boot_off  = boot_off | val[0];
        end
        default: ;
      endcase
    endfunction

    function bit mapped(logic [15:0] a);
      return (a <= ADDR_ROM_END) || (a >= ADDR_RAM_BEGIN && a <= ADDR_RAM_END);
    endfunction

    // RAM bank is masked by the bank count, then wraps over four banks
    function logic [14:0] ram_slot(logic [15:0] a);
      logic [4:0] bank;
      bank = mode_sel ? {3'b000, bank_hi} : 5'd0;
      bank = bank & (ram_count - 5'd1);
      return {bank[1:0], a[12:0]};
    endfunction

    function void map_access(access_t acc);
      logic        cpu_hit;
      logic        dma_hit;
      logic [15:0] a;
      logic [7:0]  d;
      logic        rd;
      logic        wr;
      logic [7:0]  mask;
      logic [7:0]  bank;
      result_t     r;
      cpu_hit = mapped(acc.cpu_addr) && (acc.cpu_read || acc.cpu_write);
      dma_hit = mapped(acc.dma_addr) && acc.dma_read;
      a  = dma_hit ? acc.dma_addr  : acc.cpu_addr;
      d  = dma_hit ? acc.dma_data  : acc.cpu_data;
      rd = dma_hit ? acc.dma_read  : acc.cpu_read;
      wr = dma_hit ? acc.dma_write : acc.cpu_write;
      r = '0;
      mask = rom_count - 8'd1;

      // a write wins over a read on the same beat
      if (wr) begin
        if (a <= ADDR_RAM_EN_END) begin
          ram_on = (d[3:0] == RAM_EN_KEY);
        end else if (a <= ADDR_ROM_LO_END) begin
          bank_lo = d[4:0];
        end else if (a <= ADDR_BANK_HI_END) begin
          bank_hi = d[1:0];
        end else if (a <= ADDR_ROM_END) begin
          mode_sel = d[0];
        end else if (a >= ADDR_RAM_BEGIN && a <= ADDR_RAM_END) begin
          if (ram_on && ram_count != 0) begin
            cart_mem[ram_slot(a)] = d;
            dirty = 1'b1;
          end
        end else if (a == ADDR_BOOT_OFF) begin
          if (d != 8'h00) boot_off = 1'b1;
        end
      end else if (rd) begin
        if (a <= ADDR_BOOT_END && !boot_off) begin
          r.data_source    = SRC_BOOT;
          r.memory_address = {5'd0, a};
        end else if (a <= ADDR_ROM_LO_END) begin
          // lower window: bank 0, or the high bits in mode 1
          bank = 8'd0;
          if (mode_sel && rom_count != 0) bank = {1'b0, bank_hi, 5'd0} & mask;
          r.data_source    = SRC_ROM;
          r.memory_address = {bank[6:0], a[13:0]};
        end else if (a <= ADDR_ROM_END) begin
          // upper window: low bank 0 reads as 1
          bank = {1'b0, bank_hi, bank_lo};
          if (bank_lo == 5'd0) bank[0] = 1'b1;
          if (rom_count != 0) bank = bank & mask;
          r.data_source    = SRC_ROM;
          r.memory_address = {bank[6:0], a[13:0]};
        end else if (a >= ADDR_RAM_BEGIN && a <= ADDR_RAM_END) begin
          if (ram_on && ram_count != 0) d = cart_mem[ram_slot(a)];
        end
      end

      r.cpu_ack     = !dma_hit && cpu_hit;
      r.dma_ack     = dma_hit;
      r.read_data   = d;
      r.ram_written = dirty;
      due_results.push_back(r);
    endfunction

    function void check_field(string name, logic [20:0] want, logic [20:0] got);
      if (want !== got) begin
        $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void match_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        $error("result beat with no access outstanding");
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      check_field("cpu_ack", 21'(want.cpu_ack), 21'(got.cpu_ack));
      check_field("dma_ack", 21'(want.dma_ack), 21'(got.dma_ack));
      check_field("read_data", 21'(want.read_data), 21'(got.read_data));
      check_field("data_source", 21'(want.data_source), 21'(got.data_source));
      check_field("memory_address", want.memory_address, got.memory_address);
      check_field("ram_written", 21'(want.ram_written), 21'(got.ram_written));
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, channels, DUT
  // --------------------------------------------------------------------------
  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  cbc_in_if  in_ch ();
  cbc_out_if out_ch ();

  cartridge_bank_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cart_map_tracker tracker;
  int unsigned     beats_sent;
  int unsigned     quiet_cycles;
  int unsigned     sink_stall;
  bit              src_idle_on;
  bit              sink_idle_on;
  bit              boot_off_allowed;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [15:0] pick_addr();
    int unsigned sel;
    sel = $urandom_range(0, 17);
    case (sel)
      0, 1:          return 16'($urandom_range(0, 16'h00FF));
      2:             return 16'($urandom_range(16'h0100, 16'h1FFF));
      3, 4:          return 16'($urandom_range(16'h2000, 16'h3FFF));
      5:             return 16'($urandom_range(16'h4000, 16'h5FFF));
      6:             return 16'($urandom_range(16'h6000, 16'h7FFF));
      7, 8, 9, 10:   return 16'($urandom_range(16'hA000, 16'hBFFF));
      11:            return 16'($urandom_range(16'h8000, 16'h9FFF));
      12:            return 16'($urandom_range(16'hC000, 16'hFFFF));
      13: begin
        if (boot_off_allowed) return ADDR_BOOT_OFF;
        return 16'($urandom);
      end
      default:       return 16'($urandom);
    endcase
  endfunction

  // RAM enable writes mostly carry the key
  function automatic logic [7:0] pick_data(logic [15:0] a);
    if (a <= ADDR_RAM_EN_END && $urandom_range(0, 2) != 0) return {4'($urandom), RAM_EN_KEY};
    return 8'($urandom);
  endfunction

  // CPU access with DMA noise that never wins (no DMA read)
  function automatic access_t cpu_beat(logic [15:0] a, logic [7:0] d, logic rd, logic wr);
    access_t acc;
    acc.cpu_addr  = a;
    acc.cpu_data  = d;
    acc.cpu_read  = rd;
    acc.cpu_write = wr;
    acc.dma_addr  = 16'($urandom);
    acc.dma_data  = 8'($urandom);
    acc.dma_read  = 1'b0;
    acc.dma_write = 1'($urandom);
    return acc;
  endfunction

  function automatic access_t rand_access();
    access_t     acc;
    int unsigned op;
    acc.cpu_addr  = pick_addr();
    acc.cpu_data  = pick_data(acc.cpu_addr);
    op = $urandom_range(0, 19);
    acc.cpu_read  = (op <= 8) || (op == 16);
    acc.cpu_write = (op >= 9) && (op <= 16);
    acc.dma_addr  = pick_addr();
    acc.dma_data  = 8'($urandom);
    acc.dma_read  = ($urandom_range(0, 3) == 0);
    acc.dma_write = ($urandom_range(0, 5) == 0);
    return acc;
  endfunction

  // one beat on the input channel, with an occasional gap ahead of it
  task automatic send_beat(access_t acc);
    if (src_idle_on && $urandom_range(0, 9) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cpu_addr  <= acc.cpu_addr;
    in_ch.cpu_data  <= acc.cpu_data;
    in_ch.cpu_read  <= acc.cpu_read;
    in_ch.cpu_write <= acc.cpu_write;
    in_ch.dma_addr  <= acc.dma_addr;
    in_ch.dma_data  <= acc.dma_data;
    in_ch.dma_read  <= acc.dma_read;
    in_ch.dma_write <= acc.dma_write;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    beats_sent++;
  endtask

  // hold the sender until every promised result is back
  task automatic settle_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    tracker.write_reg(idx, val);
  endtask

  task automatic load_setting(logic [7:0] rom, logic [4:0] ram, logic skip);
    write_reg(CFG_ROM_BANK_COUNT, rom);
    write_reg(CFG_RAM_BANK_COUNT, {3'b000, ram});
    write_reg(CFG_BOOT_ROM_SKIP, {7'd0, skip});
    cfg_we <= 1'b0;
  endtask

  // enable RAM, pick a bank and mode, then hammer a few RAM locations
  task automatic run_ram_burst();
    logic [12:0] offs [4];
    logic [12:0] off;
    access_t     acc;
    foreach (offs[i]) offs[i] = 13'($urandom);
    send_beat(cpu_beat(16'($urandom_range(0, 16'h1FFF)), {4'($urandom), RAM_EN_KEY}, 1'b0, 1'b1));
    send_beat(cpu_beat(16'($urandom_range(16'h4000, 16'h5FFF)), 8'($urandom), 1'b0, 1'b1));
    send_beat(cpu_beat(16'($urandom_range(16'h6000, 16'h7FFF)), 8'($urandom), 1'b0, 1'b1));
    repeat ($urandom_range(6, 14)) begin
      off = offs[$urandom_range(0, 3)];
      case ($urandom_range(0, 5))
        0, 1: send_beat(cpu_beat({3'b101, off}, 8'($urandom), 1'($urandom), 1'b1));
        2, 3: send_beat(cpu_beat({3'b101, off}, 8'($urandom), 1'b1, 1'b0));
        4: begin
          acc = rand_access();
          acc.dma_addr  = {3'b101, off};
          acc.dma_read  = 1'b1;
          acc.dma_write = ($urandom_range(0, 3) == 0);
          send_beat(acc);
        end
        default: send_beat(cpu_beat(16'($urandom_range(0, 16'h7FFF)), 8'($urandom), 1'b1, 1'b0));
      endcase
    end
    if ($urandom_range(0, 2) == 0)
      send_beat(cpu_beat(16'($urandom_range(0, 16'h1FFF)), 8'($urandom), 1'b0, 1'b1));
  endtask

  task automatic run_random(int unsigned count);
    int unsigned target;
    target = beats_sent + count;
    while (beats_sent < target) begin
      if ($urandom_range(0, 9) < 4) run_ram_burst();
      else send_beat(rand_access());
    end
  endtask

  task automatic run_phase(logic [7:0] rom, logic [4:0] ram, logic skip,
                           bit src_idle, bit sink_idle, bit hold_mid, int unsigned count);
    settle_results();
    load_setting(rom, ram, skip);
    src_idle_on  = src_idle;
    sink_idle_on = sink_idle;
    if (hold_mid) begin
      run_random(count / 2);
      settle_results();
      run_random(count - count / 2);
    end else begin
      run_random(count);
    end
  endtask

  // field extremes, every register write, priority and corner cases
  task automatic run_directed();
    access_t acc;
    // boot ROM window edges, then ROM bank 0 and the low-bank-zero remap
    send_beat(cpu_beat(16'h0000, 8'h00, 1'b1, 1'b0));
    send_beat(cpu_beat(16'h00FF, 8'hFF, 1'b1, 1'b0));
    send_beat(cpu_beat(16'h0100, 8'h81, 1'b1, 1'b0));
    send_beat(cpu_beat(16'h4000, 8'h42, 1'b1, 1'b0));
    // top banks, then mode 1 on the lower window
    send_beat(cpu_beat(16'h2000, 8'h1F, 1'b0, 1'b1));
    send_beat(cpu_beat(16'h4000, 8'h03, 1'b0, 1'b1));
    send_beat(cpu_beat(16'h7FFF, 8'h7E, 1'b1, 1'b0));
    send_beat(cpu_beat(16'h6000, 8'h01, 1'b0, 1'b1));
    send_beat(cpu_beat(16'h3FFF, 8'h3C, 1'b1, 1'b0));
    // RAM while disabled, then enabled
    send_beat(cpu_beat(16'hA000, 8'h55, 1'b0, 1'b1));
    send_beat(cpu_beat(16'hA000, 8'h5A, 1'b1, 1'b0));
    send_beat(cpu_beat(16'h0000, 8'h0A, 1'b0, 1'b1));
    send_beat(cpu_beat(16'hBFFF, 8'hA5, 1'b0, 1'b1));
    send_beat(cpu_beat(16'hBFFF, 8'h00, 1'b1, 1'b0));
    // read and write together: write happens
    send_beat(cpu_beat(16'hA001, 8'h3C, 1'b1, 1'b1));
    // DMA read in RAM space beats a CPU write
    acc = cpu_beat(16'hA000, 8'h99, 1'b0, 1'b1);
    acc.dma_addr = 16'hBFFF;
    acc.dma_data = 8'h12;
    acc.dma_read = 1'b1;
    acc.dma_write = 1'b0;
    send_beat(acc);
    // DMA read plus write: the DMA write lands
    acc = cpu_beat(16'h4000, 8'h11, 1'b1, 1'b0);
    acc.dma_addr = 16'hA002;
    acc.dma_data = 8'hC3;
    acc.dma_read = 1'b1;
    acc.dma_write = 1'b1;
    send_beat(acc);
    // DMA write alone never wins
    acc = cpu_beat(16'hA001, 8'h00, 1'b1, 1'b0);
    acc.dma_addr = 16'hA000;
    acc.dma_data = 8'h77;
    acc.dma_write = 1'b1;
    send_beat(acc);
    // DMA read outside the map does not win either
    acc = cpu_beat(16'h5ABC, 8'h0F, 1'b1, 1'b0);
    acc.dma_addr = 16'hC000;
    acc.dma_data = 8'hF0;
    acc.dma_read = 1'b1;
    send_beat(acc);
    // unmapped read echoes, zero to the boot latch is a no-op
    send_beat(cpu_beat(16'hFFFF, 8'hFF, 1'b1, 1'b0));
    send_beat(cpu_beat(ADDR_BOOT_OFF, 8'h00, 1'b0, 1'b1));
    send_beat(cpu_beat(16'h0050, 8'h50, 1'b1, 1'b0));
    send_beat(cpu_beat(16'h1234, 8'h34, 1'b0, 1'b0));
    // low bank masked to zero reads as bank 1 within the high bits
    send_beat(cpu_beat(16'h2000, 8'hE0, 1'b0, 1'b1));
    send_beat(cpu_beat(16'h5ABC, 8'h00, 1'b1, 1'b0));
    // non-key low nibble disables RAM
    send_beat(cpu_beat(16'h1000, 8'h1B, 1'b0, 1'b1));
  endtask

  // --------------------------------------------------------------------------
  // Channel monitor and result-side backpressure
  // --------------------------------------------------------------------------
  initial begin
    tracker = new();
    out_ch.ready <= 1'b0;
    quiet_cycles = 0;
    sink_stall = 0;
    forever begin
      @(posedge clk);
      quiet_cycles++;
      if (rst_n && in_ch.valid && in_ch.ready) begin
        tracker.map_access({in_ch.cpu_addr, in_ch.cpu_data, in_ch.cpu_read, in_ch.cpu_write,
                            in_ch.dma_addr, in_ch.dma_data, in_ch.dma_read, in_ch.dma_write});
        quiet_cycles = 0;
      end
      if (rst_n && out_ch.valid && out_ch.ready) begin
        tracker.match_result({out_ch.cpu_ack, out_ch.dma_ack, out_ch.read_data,
                              out_ch.data_source, out_ch.memory_address, out_ch.ram_written});
        quiet_cycles = 0;
      end
      // random stall bursts while sink_idle_on is set
      if (sink_stall != 0) begin
        sink_stall--;
        out_ch.ready <= 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 9) == 0) begin
        sink_stall = $urandom_range(1, 18) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on channel activity
  initial begin
    @(posedge clk);
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("cartridge_bank_controller regression: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_ROM_BANK_COUNT;
    cfg_data        <= 8'h00;
    in_ch.valid     <= 1'b0;
    in_ch.cpu_addr  <= '0;
    in_ch.cpu_data  <= '0;
    in_ch.cpu_read  <= 1'b0;
    in_ch.cpu_write <= 1'b0;
    in_ch.dma_addr  <= '0;
    in_ch.dma_data  <= '0;
    in_ch.dma_read  <= 1'b0;
    in_ch.dma_write <= 1'b0;
    beats_sent       = 0;
    src_idle_on      = 1'b1;
    sink_idle_on     = 1'b1;
    boot_off_allowed = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // boot ROM still live for the directed part
    load_setting(8'd128, 5'd4, 1'b0);
    run_directed();
    run_random(170);

    run_phase(8'd0,   5'd0,  1'b0, 1'b1, 1'b1, 1'b0, 195);
    run_phase(8'd2,   5'd1,  1'b0, 1'b1, 1'b0, 1'b0, 195);
    run_phase(8'd3,   5'd16, 1'b0, 1'b0, 1'b1, 1'b1, 195);
    // from here on the boot ROM is off for good
    boot_off_allowed = 1'b1;
    run_phase(8'd64,  5'd2,  1'b1, 1'b1, 1'b1, 1'b0, 195);
    run_phase(8'd5,   5'd3,  1'b0, 1'b1, 1'b1, 1'b0, 195);
    // closing stretch at full rate
    run_phase(8'd128, 5'd4,  1'b0, 1'b0, 1'b0, 1'b0, 200);
    settle_results();

    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("cartridge_bank_controller regression: pass");
    end else begin
      $display("cartridge_bank_controller regression: fail");
    end
    $finish;
  end

endmodule
